/* hw/rtl/fddq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fddq_pkg
// Types and codes shared by the flow dedup delivery queue.
// ----------------------------------------------------------------------------
package fddq_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_MAX   = 2'd1,
    OP_TAKE  = 2'd2,
    OP_CLEAR = 2'd3
  } fddq_op_t;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_FOUND = 3'd3,
    ST_NONE  = 3'd4,
    ST_DONE  = 3'd5
  } fddq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMPACT
  } fddq_state_t;

  typedef struct packed {
    fddq_op_t    command;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [7:0]  packet_kind;
    logic [30:0] seq_in;
    logic [15:0] packet_handle;
    logic        any_source;
  } fddq_req_t;

  typedef struct packed {
    fddq_status_t status;
    logic [30:0]  seq_out;
    logic [15:0]  handle_out;
  } fddq_rsp_t;

  // One stored descriptor, taken mark included.
  typedef struct packed {
    logic        taken;
    logic [31:0] source;
    logic [31:0] dest;
    logic [7:0]  kind;
    logic [30:0] seq;
    logic [15:0] handle;
  } fddq_entry_t;

endpackage

/* hw/rtl/flow_dedup_delivery_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_dedup_delivery_queue
// Arrival-ordered descriptor queue with duplicate drop, per-flow max
// sequence query, take-oldest with compaction, and per-flow sequence clear.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result
// shows on result for a single cycle with done high, and there is no way to
// hold it off, so capture it on that edge. Add, max query, clear and a take
// that finds nothing scan every stored descriptor, oldest first, before
// done; a take that hits an entry stops its scan there and then walks back
// over the older entries to drop taken ones and close up the survivors.
// The scan and the walk back read the descriptor memory through its
// single read port, one entry a cycle. busy drops in the cycle done is
// high, so a new command can go in right on the result edge.
// ----------------------------------------------------------------------------
module flow_dedup_delivery_queue import fddq_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  fddq_req_t request,
  output logic      done,
  output fddq_rsp_t result
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] p);
    return (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  // Control state
  fddq_state_t      state, state_next;
  logic [IDX_W-1:0] head, head_next;        // physical slot of oldest entry
  logic [CNT_W-1:0] count, count_next;      // entries stored
  logic             chk_vld, chk_vld_next;  // read data valid this cycle
  logic             done_next;

  // Working registers
  fddq_req_t        req, req_next;
  logic [CNT_W-1:0] rd_log, rd_log_next;    // scan: next position; compact: left
  logic [IDX_W-1:0] rd_phys, rd_phys_next;
  logic [IDX_W-1:0] chk_log, chk_log_next;
  logic [IDX_W-1:0] chk_phys, chk_phys_next;
  logic [IDX_W-1:0] wr_phys, wr_phys_next;  // compact: lowest survivor slot
  logic [CNT_W-1:0] live, live_next;        // compact: entries that stay
  logic             dup, dup_next;
  logic [30:0]      max_seq, max_seq_next;
  logic [15:0]      hold_handle, hold_handle_next;
  fddq_rsp_t        result_next;

  // Memory ports
  logic             mem_wr_en, mem_rd_en;
  logic [IDX_W-1:0] mem_wr_addr;
  fddq_entry_t      mem_wr_data, rdata;

  fddq_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_phys),
    .rd_data (rdata)
  );

  // Field compares on the entry just read
  logic src_eq, dst_eq, kind_eq, seq_eq, take_hit;
  assign src_eq   = (rdata.source == req.source_addr);
  assign dst_eq   = (rdata.dest == req.dest_addr);
  assign kind_eq  = (rdata.kind == req.packet_kind);
  assign seq_eq   = (rdata.seq == req.seq_in);
  assign take_hit = chk_vld && (req.command == OP_TAKE) &&
                    (req.any_source || src_eq) && !rdata.taken;

  // Append slot = head + count, wrapped
  logic [CNT_W:0]   tail_sum, tail_wrap;
  logic [IDX_W-1:0] tail;
  assign tail_sum  = {1'b0, count} + (CNT_W + 1)'(head);
  assign tail_wrap = (tail_sum >= DEPTH_SUM) ? tail_sum - DEPTH_SUM : tail_sum;
  assign tail      = tail_wrap[IDX_W-1:0];

  logic scan_end, compact_end;
  assign scan_end    = (rd_log == count) && !chk_vld;
  assign compact_end = (rd_log == '0) && !chk_vld;

  assign busy = (state != S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (take_hit) begin
          state_next = S_COMPACT;
        end else if (scan_end) begin
          state_next = S_IDLE;
        end
      end
      S_COMPACT: begin
        if (compact_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    req_next         = req;
    head_next        = head;
    count_next       = count;
    rd_log_next      = rd_log;
    rd_phys_next     = rd_phys;
    chk_vld_next     = 1'b0;
    chk_log_next     = chk_log;
    chk_phys_next    = chk_phys;
    wr_phys_next     = wr_phys;
    live_next        = live;
    dup_next         = dup;
    max_seq_next     = max_seq;
    hold_handle_next = hold_handle;
    done_next        = 1'b0;
    result_next      = result;
    mem_rd_en        = 1'b0;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = chk_phys;
    mem_wr_data      = rdata;

    case (state)
      S_IDLE: begin
        if (start) begin
          req_next         = request;
          rd_log_next      = '0;
          rd_phys_next     = head;
          dup_next         = 1'b0;
          max_seq_next     = '0;
          hold_handle_next = '0;
        end
      end

      S_SCAN: begin
        if (rd_log != count) begin
          mem_rd_en     = 1'b1;
          rd_log_next   = rd_log + 1'b1;
          rd_phys_next  = wrap_inc(rd_phys);
          chk_vld_next  = 1'b1;
          chk_log_next  = rd_log[IDX_W-1:0];
          chk_phys_next = rd_phys;
        end
        if (chk_vld) begin
          case (req.command)
            OP_ADD: begin
              if (src_eq && dst_eq && kind_eq && seq_eq) begin
                dup_next = 1'b1;
              end
            end
            OP_MAX: begin
              if (src_eq && dst_eq && (rdata.seq > max_seq)) begin
                max_seq_next = rdata.seq;
              end
            end
            OP_CLEAR: begin
              if (src_eq && dst_eq && kind_eq) begin
                mem_wr_en       = 1'b1;
                mem_wr_data.seq = '0;
              end
            end
            OP_TAKE: begin
              if (take_hit) begin
                // Mark it, then walk back over the older entries.
                mem_wr_en         = 1'b1;
                mem_wr_data.taken = 1'b1;
                hold_handle_next  = rdata.handle;
                rd_log_next       = CNT_W'(chk_log);
                rd_phys_next      = wrap_dec(chk_phys);
                wr_phys_next      = chk_phys;
                live_next         = count - CNT_W'(chk_log);
                chk_vld_next      = 1'b0;
              end
            end
            default: ;
          endcase
        end
        if (scan_end) begin
          done_next              = 1'b1;
          result_next.seq_out    = '0;
          result_next.handle_out = '0;
          case (req.command)
            OP_ADD: begin
              if (dup) begin
                result_next.status = ST_DUP;
              end else if (count == DEPTH_CNT) begin
                result_next.status = ST_FULL;
              end else begin
                result_next.status = ST_ADDED;
                mem_wr_en          = 1'b1;
                mem_wr_addr        = tail;
                mem_wr_data        = '{taken:  1'b0,
                                       source: req.source_addr,
                                       dest:   req.dest_addr,
                                       kind:   req.packet_kind,
                                       seq:    req.seq_in,
                                       handle: req.packet_handle};
                count_next         = count + 1'b1;
              end
            end
            OP_MAX: begin
              result_next.status  = ST_DONE;
              result_next.seq_out = max_seq;
            end
            OP_TAKE:  result_next.status = ST_NONE;
            OP_CLEAR: result_next.status = ST_DONE;
            default:  result_next.status = ST_DONE;
          endcase
        end
      end

      S_COMPACT: begin
        if (rd_log != '0) begin
          mem_rd_en    = 1'b1;
          rd_log_next  = rd_log - 1'b1;
          rd_phys_next = wrap_dec(rd_phys);
          chk_vld_next = 1'b1;
        end
        // Untaken entries slide up next to the survivors; taken ones drop.
        if (chk_vld && !rdata.taken) begin
          mem_wr_en    = 1'b1;
          mem_wr_addr  = wrap_dec(wr_phys);
          wr_phys_next = wrap_dec(wr_phys);
          live_next    = live + 1'b1;
        end
        if (compact_end) begin
          head_next              = wr_phys;
          count_next             = live;
          done_next              = 1'b1;
          result_next.status     = ST_FOUND;
          result_next.seq_out    = '0;
          result_next.handle_out = hold_handle;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      count   <= '0;
      chk_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      count   <= count_next;
      chk_vld <= chk_vld_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    req         <= req_next;
    rd_log      <= rd_log_next;
    rd_phys     <= rd_phys_next;
    chk_log     <= chk_log_next;
    chk_phys    <= chk_phys_next;
    wr_phys     <= wr_phys_next;
    live        <= live_next;
    dup         <= dup_next;
    max_seq     <= max_seq_next;
    hold_handle <= hold_handle_next;
    result      <= result_next;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("entry count beyond depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not start work");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> (state != S_IDLE))
    else $error("memory write while idle");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result beats");

endmodule

/* hw/rtl/fddq_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fddq_mem
// Descriptor store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fddq_mem import fddq_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [AW-1:0] wr_addr,
  input  fddq_entry_t wr_data,
  input  logic        rd_en,
  input  logic [AW-1:0] rd_addr,
  output fddq_entry_t rd_data
);

  fddq_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
